// ===== sv/keyword_substitution_cipher_assert.svh =====
// Assertion macros for the keyword substitution cipher checker.
// Included by the checker file only; depends on nothing else.
`ifndef KEYWORD_SUBSTITUTION_CIPHER_ASSERT_SVH
`define KEYWORD_SUBSTITUTION_CIPHER_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent.
`define KWSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define KWSC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== sv/kwsc_pkg.sv =====
// Shared types, constants and the letter decoder of the keyword substitution cipher.
// Used by the controller, the datapath, the top level and the checker.
package kwsc_pkg;

    localparam int LETTERS = 26;
    localparam int IDX_W   = 5;
    localparam int BYTE_W  = 8;

    localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [BYTE_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [BYTE_W-1:0] CHAR_LOWER_Z = 8'h7A;

    localparam logic [IDX_W-1:0] LAST_LETTER = IDX_W'(LETTERS - 1);

    typedef enum logic [1:0] {
        REQ_CLEAR    = 2'd0,
        REQ_KEY      = 2'd1,
        REQ_FINALIZE = 2'd2,
        REQ_TEXT     = 2'd3
    } req_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             clear;
        logic             key_load;
        logic             fill_step;
        logic             inv_step;
        logic             text_load;
        logic [IDX_W-1:0] step_idx;
    } kwsc_cmd_t;

    typedef struct packed {
        logic             is_letter;
        logic             lower;
        logic [IDX_W-1:0] idx;
    } letter_t;

    // Classifies an ASCII byte; idx is zero for non-letters.
    function automatic letter_t decode_letter(input logic [BYTE_W-1:0] b);
        letter_t          res;
        logic [BYTE_W-1:0] diff;
        res  = '0;
        diff = '0;
        if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z)
        begin
            diff          = b - CHAR_UPPER_A;
            res.is_letter = 1'b1;
            res.idx       = diff[IDX_W-1:0];
        end
        else if (b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z)
        begin
            diff          = b - CHAR_LOWER_A;
            res.is_letter = 1'b1;
            res.lower     = 1'b1;
            res.idx       = diff[IDX_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== sv/kwsc_ctrl.sv =====
// Controller of the keyword substitution cipher: input handshake, finalize walk, output valid.
// Depends on kwsc_pkg.
module kwsc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         req_type,
    output logic               out_valid,
    input  logic               out_ready,
    output kwsc_pkg::kwsc_cmd_t cmd
);
    import kwsc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FILL,
        S_INV
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] step_cnt_reg, step_cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             accept;
    req_t             req;

    assign req = req_t'(req_type);

    // A text item needs the output register free, or draining in this cycle.
    assign in_ready = (state_reg == S_IDLE) &&
                      ((req != REQ_TEXT) || !out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        cmd.step_idx   = step_cnt_reg;
        state_next     = state_reg;
        step_cnt_next  = step_cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req)
                        REQ_CLEAR:    cmd.clear = 1'b1;
                        REQ_KEY:      cmd.key_load = 1'b1;
                        REQ_FINALIZE:
                        begin
                            state_next    = S_FILL;
                            step_cnt_next = LAST_LETTER;
                        end
                        REQ_TEXT:
                        begin
                            cmd.text_load  = 1'b1;
                            out_valid_next = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            // Offer the letters from Z down to A.
            S_FILL:
            begin
                cmd.fill_step = 1'b1;
                if (step_cnt_reg == '0)
                begin
                    state_next = S_INV;
                end
                else
                begin
                    step_cnt_next = step_cnt_reg - 1'b1;
                end
            end
            // Build the inverse table one forward entry per cycle.
            S_INV:
            begin
                cmd.inv_step = 1'b1;
                if (step_cnt_reg == LAST_LETTER)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    step_cnt_next = step_cnt_reg + 1'b1;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_cnt_reg  <= step_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== sv/kwsc_datapath.sv =====
// Datapath of the keyword substitution cipher: tables, used mask, key length, output byte.
// Depends on kwsc_pkg; driven by commands from kwsc_ctrl.
module kwsc_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  kwsc_pkg::kwsc_cmd_t         cmd,
    input  logic [kwsc_pkg::BYTE_W-1:0] byte_in,
    input  logic                        cfg_wr_en,
    input  logic                        cfg_wr_data,
    output logic [kwsc_pkg::BYTE_W-1:0] byte_out
);
    import kwsc_pkg::*;

    logic [IDX_W-1:0]   fwd_table_reg [LETTERS];
    logic [IDX_W-1:0]   inv_table_reg [LETTERS];
    logic [LETTERS-1:0] used_reg, used_next;
    logic [IDX_W-1:0]   key_len_reg, key_len_next;
    logic               direction_reg;
    logic [BYTE_W-1:0]  byte_out_reg, byte_out_next;

    letter_t           dec;
    logic [IDX_W-1:0]  fwd_raddr;
    logic [IDX_W-1:0]  fwd_rdata;
    logic [IDX_W-1:0]  cand;
    logic              cand_valid;
    logic              append;
    logic [IDX_W-1:0]  mapped;
    logic [BYTE_W-1:0] base;

    assign dec       = decode_letter(byte_in);
    assign fwd_raddr = cmd.inv_step ? cmd.step_idx : dec.idx;
    assign fwd_rdata = fwd_table_reg[fwd_raddr];

    // Letter offered for appending: a keyword letter or the finalize walk letter.
    assign cand       = cmd.fill_step ? cmd.step_idx : dec.idx;
    assign cand_valid = cmd.fill_step || (cmd.key_load && dec.is_letter);
    assign append     = cand_valid && !used_reg[cand] && (key_len_reg < IDX_W'(LETTERS));

    always_comb
    begin
        used_next    = used_reg;
        key_len_next = key_len_reg;
        if (cmd.clear)
        begin
            used_next    = '0;
            key_len_next = '0;
        end
        else if (append)
        begin
            used_next    = used_reg | (LETTERS'(1) << cand);
            key_len_next = key_len_reg + 1'b1;
        end
    end

    assign mapped        = direction_reg ? inv_table_reg[dec.idx] : fwd_rdata;
    assign base          = dec.lower ? CHAR_LOWER_A : CHAR_UPPER_A;
    assign byte_out_next = dec.is_letter ? (base + BYTE_W'(mapped)) : byte_in;
    assign byte_out      = byte_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LETTERS; i++)
            begin
                fwd_table_reg[i] <= IDX_W'(i);
                inv_table_reg[i] <= IDX_W'(i);
            end
            used_reg      <= '0;
            key_len_reg   <= '0;
            direction_reg <= 1'b0;
        end
        else
        begin
            if (append)
            begin
                fwd_table_reg[key_len_reg] <= cand;
            end
            if (cmd.inv_step)
            begin
                inv_table_reg[fwd_rdata] <= cmd.step_idx;
            end
            used_reg    <= used_next;
            key_len_reg <= key_len_next;
            if (cfg_wr_en)
            begin
                direction_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.text_load)
        begin
            byte_out_reg <= byte_out_next;
        end
    end

endmodule

// ===== sv/keyword_substitution_cipher.sv =====
// Keyword substitution cipher on ASCII bytes, top level.
// Channels: input items (req_type, byte_in) on in_valid/in_ready, results (byte_out)
// on out_valid/out_ready, and a one-bit direction register on cfg_wr_en/cfg_wr_data
// (0 encrypts, 1 decrypts). The user must see that it is written only while the block
// is idle; the block itself does not enforce this. Clear and keyword items give no
// result. A text item's byte appears on byte_out the cycle after acceptance, held in
// an output register. A finalize item is accepted, then the letters Z down to A are
// offered to the alphabet and the inverse table is written, one entry per cycle
// through the single write port of each table; no item is accepted meanwhile.
// If the receiver stalls, the result stays on byte_out; clear, keyword and finalize
// items are still accepted, and a text item waits until the output register drains.
// Reset (rst_n, asynchronous, active low) sets both tables to identity, empties the
// keyword, selects encryption and drops out_valid. It needs no clearing pass.
// Depends on kwsc_pkg, kwsc_ctrl and kwsc_datapath.
module keyword_substitution_cipher (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  req_type,
    input  logic [kwsc_pkg::BYTE_W-1:0] byte_in,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [kwsc_pkg::BYTE_W-1:0] byte_out,
    input  logic                        cfg_wr_en,
    input  logic                        cfg_wr_data
);
    import kwsc_pkg::*;

    kwsc_cmd_t cmd;

    kwsc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    kwsc_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .byte_in     (byte_in),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .byte_out    (byte_out)
    );

endmodule

// ===== sv/kwsc_checker.sv =====
// Port-level checker for the keyword substitution cipher, bound to the top level.
// Depends on kwsc_pkg and keyword_substitution_cipher_assert.svh.
`include "keyword_substitution_cipher_assert.svh"

module kwsc_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic [1:0]                  req_type,
    input logic [kwsc_pkg::BYTE_W-1:0] byte_in,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [kwsc_pkg::BYTE_W-1:0] byte_out,
    input logic                        cfg_wr_en,
    input logic                        cfg_wr_data
);
    import kwsc_pkg::*;

    logic in_acc;
    logic text_acc;
    logic non_letter;
    logic cfg_seen;

    assign in_acc     = in_valid && in_ready;
    assign text_acc   = in_acc && (req_type == REQ_TEXT);
    assign non_letter = !((byte_in >= CHAR_UPPER_A && byte_in <= CHAR_UPPER_Z) ||
                          (byte_in >= CHAR_LOWER_A && byte_in <= CHAR_LOWER_Z));
    assign cfg_seen   = cfg_wr_en || cfg_wr_data;

    `KWSC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(byte_out), "stalled result changed")
    `KWSC_ASSERT_NEXT(a_text_result, clk, rst_n, text_acc, out_valid, "text item gave no result")
    `KWSC_ASSERT_NEXT(a_pass_through, clk, rst_n, text_acc && non_letter, byte_out == $past(byte_in), "non-letter byte was altered")
    `KWSC_ASSERT_NEXT(a_finalize_busy, clk, rst_n, in_acc && (req_type == REQ_FINALIZE), !in_ready, "item taken during finalize walk")
    `KWSC_ASSERT_SAME(a_no_spurious, clk, rst_n, out_valid && !$past(out_valid) && !cfg_seen, $past(text_acc), "result without a text item")

endmodule

bind keyword_substitution_cipher kwsc_checker u_kwsc_checker (.*);
